// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/bpc_pkg.sv -----
// Package for the barometric pressure compensation block.
// Holds the word types, register indexes, constants and shared helpers.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  localparam int DIV_W    = 32;
  localparam int ADDR_W   = 5;
  localparam int CFG_DW   = 64;

  // Register indexes, taken from paddr[4:3].
  typedef enum logic [1:0] {
    REG_AC1_AC4  = 2'd0,
    REG_AC5_B2   = 2'd1,
    REG_MC_MD    = 2'd2,
    REG_OSS      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic signed [31:0] pressure;
    logic               divide_error;
  } out_word_t;

  // Payload carried alongside the temperature divider.
  typedef struct packed {
    logic signed [31:0] x1;
    logic [31:0]        up;
    logic               neg;
    logic               err;
  } diva_pay_t;

  // Payload carried alongside the pressure divider.
  typedef struct packed {
    logic signed [31:0] t;
    logic               err;
    logic               dbl;
  } divb_pay_t;

  localparam logic signed [31:0] C_B6_OFS  = 32'sd4000;
  localparam logic signed [31:0] C_P_X1    = 32'sd3038;
  localparam logic signed [31:0] C_P_X2    = -32'sd7357;
  localparam logic signed [31:0] C_P_OFS   = 32'sd3791;
  localparam logic [31:0]        C_B7_MUL  = 32'd50000;
  localparam logic [31:0]        C_B4_OFS  = 32'd32768;

  // Signed division by 2^k that truncates toward zero.
  function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] x,
                                                   input int unsigned k);
    logic signed [31:0] bias;
    bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
    return (x + bias) >>> k;
  endfunction

  // Sign extension of a 16-bit field.
  function automatic logic signed [31:0] sx16(input logic [15:0] v);
    return signed'({{16{v[15]}}, v});
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bpc_div.sv -----
// Pipelined unsigned divider, one quotient bit per stage.
// Depends on bpc_pkg for the data width; a side payload travels with each word.
`timescale 1ns / 1ps
`default_nettype none

module bpc_div #(
  parameter int PW = 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [bpc_pkg::DIV_W-1:0] in_num,
  input  wire logic [bpc_pkg::DIV_W-1:0] in_den,
  input  wire logic [PW-1:0]             in_pay,
  output logic                           out_valid,
  output logic [bpc_pkg::DIV_W-1:0]      out_quot,
  output logic [PW-1:0]                  out_pay
);
  import bpc_pkg::*;

  localparam int N = DIV_W;

  logic [N-1:0]  rem_r [N];
  logic [N-1:0]  num_r [N];
  logic [N-1:0]  den_r [N];
  logic [N-1:0]  quo_r [N];
  logic [PW-1:0] pay_r [N];
  logic [N-1:0]  vld_r;

  logic [N-1:0]  rem_nxt [N];
  logic [N-1:0]  num_nxt [N];
  logic [N-1:0]  quo_nxt [N];

  // One restoring step per stage: shift in the next numerator bit, try to subtract.
  always_comb begin
    logic [N-1:0] r_in, n_in, d_in, q_in;
    logic [N:0]   trial;
    for (int s = 0; s < N; s++) begin
      r_in = (s == 0) ? '0 : rem_r[(s == 0) ? 0 : s-1];
      n_in = (s == 0) ? in_num : num_r[(s == 0) ? 0 : s-1];
      d_in = (s == 0) ? in_den : den_r[(s == 0) ? 0 : s-1];
      q_in = (s == 0) ? '0 : quo_r[(s == 0) ? 0 : s-1];
      trial = {r_in, n_in[N-1]};
      if (trial >= {1'b0, d_in}) begin
        rem_nxt[s] = N'(trial - {1'b0, d_in});
        quo_nxt[s] = {q_in[N-2:0], 1'b1};
      end else begin
        rem_nxt[s] = trial[N-1:0];
        quo_nxt[s] = {q_in[N-2:0], 1'b0};
      end
      num_nxt[s] = {n_in[N-2:0], 1'b0};
    end
  end

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_valid};
    end
  end

  // Stage data registers.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < N; s++) begin
        rem_r[s] <= rem_nxt[s];
        num_r[s] <= num_nxt[s];
        quo_r[s] <= quo_nxt[s];
        den_r[s] <= (s == 0) ? in_den : den_r[(s == 0) ? 0 : s-1];
        pay_r[s] <= (s == 0) ? in_pay : pay_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_quot  = quo_r[N-1];
  assign out_pay   = pay_r[N-1];

endmodule

`default_nettype wire

// ----- rtl/core/barometric_pressure_compensation_top.sv -----
// Barometric pressure compensation, fully pipelined.
// One word enters per cycle while the pipeline is not stalled.
// Depth is set by two 32-stage bit-per-stage dividers and 16 arithmetic stages.
// The whole pipeline stalls together when the output register is full and not taken.
// Synchronous active-low reset clears valid bits and coefficient registers.
`timescale 1ns / 1ps
`default_nettype none

module barometric_pressure_compensation_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire bpc_pkg::in_word_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output bpc_pkg::out_word_t              out_data,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [bpc_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [bpc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [bpc_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import bpc_pkg::*;

  // Configuration registers.
  logic [63:0] c0_r, c1_r;
  logic [31:0] c2_r;
  logic [1:0]  oss_r;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r  <= '0;
      c1_r  <= '0;
      c2_r  <= '0;
      oss_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_AC1_AC4: c0_r  <= cfg_pwdata;
        REG_AC5_B2:  c1_r  <= cfg_pwdata;
        REG_MC_MD:   c2_r  <= cfg_pwdata[31:0];
        REG_OSS:     oss_r <= cfg_pwdata[1:0];
        default:     c0_r  <= c0_r;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      REG_AC1_AC4: cfg_prdata = c0_r;
      REG_AC5_B2:  cfg_prdata = c1_r;
      REG_MC_MD:   cfg_prdata = {32'd0, c2_r};
      REG_OSS:     cfg_prdata = {62'd0, oss_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // Coefficient fields.
  logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
  logic [31:0]        ac4;
  assign ac1 = sx16(c0_r[63:48]);
  assign ac2 = sx16(c0_r[47:32]);
  assign ac3 = sx16(c0_r[31:16]);
  assign ac4 = {16'd0, c0_r[15:0]};
  assign ac5 = signed'({16'd0, c1_r[63:48]});
  assign ac6 = signed'({16'd0, c1_r[47:32]});
  assign b1  = sx16(c1_r[31:16]);
  assign b2  = sx16(c1_r[15:0]);
  assign mc  = sx16(c2_r[31:16]);
  assign md  = sx16(c2_r[15:0]);

  // Global advance: the pipeline moves unless the output word is held.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage registers.
  logic               v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r, v11_r;
  logic               v13_r, v14_r, v15_r, v16_r, v17_r;
  logic signed [31:0] s1_m1_r;
  logic [31:0]        s1_up_r, s2_up_r;
  logic signed [31:0] s2_x1_r, s2_den_r;
  logic signed [31:0] s3_b5_r, s4_t_r, s4_b6_r;
  logic [31:0]        s3_up_r, s4_up_r, s5_up_r, s6_up_r, s7_up_r, s8_up_r, s9_up_r;
  logic               s3_err_r, s4_err_r, s5_err_r, s6_err_r, s7_err_r, s8_err_r;
  logic               s9_err_r, s10_err_r, s11_err_r;
  logic signed [31:0] s5_t_r, s6_t_r, s7_t_r, s8_t_r, s9_t_r, s10_t_r, s11_t_r;
  logic signed [31:0] s5_sqm_r, s5_m2_r, s5_m3_r;
  logic signed [31:0] s6_sq_r, s6_x2a_r, s6_x1c_r;
  logic signed [31:0] s7_mb2_r, s7_mb1_r, s7_x2a_r, s7_x1c_r;
  logic signed [31:0] s8_b3p_r, s8_x3c_r;
  logic signed [31:0] s9_b3_r;
  logic [31:0]        s9_b4m_r, s10_b4_r, s10_diff_r, s11_b4_r, s11_b7_r;
  logic signed [31:0] s13_p_r, s14_pd_r, s14_ma_r, s14_p_r;
  logic signed [31:0] s15_x1m_r, s15_x2_r, s15_p_r, s16_x1m2_r, s16_x2_r, s16_p_r;
  logic               s13_err_r, s14_err_r, s15_err_r, s16_err_r;
  logic signed [31:0] s13_t_r, s14_t_r, s15_t_r, s16_t_r;
  out_word_t          out_r;

  // Temperature divider hookup.
  logic [31:0] da_num, da_den, da_q, db_num, db_den, db_q;
  logic        da_vld, db_vld, da_neg;
  logic signed [31:0] mc_num;
  diva_pay_t   da_pay_in, da_pay;
  divb_pay_t   db_pay_in, db_pay;

  assign mc_num = mc <<< 11;
  assign da_neg = mc_num[31] ^ s2_den_r[31];
  assign da_num = mc_num[31] ? 32'(-mc_num) : mc_num;
  assign da_den = (s2_den_r == '0) ? 32'd1 :
                  (s2_den_r[31] ? 32'(-s2_den_r) : s2_den_r);
  assign da_pay_in = '{x1: s2_x1_r, up: s2_up_r, neg: da_neg, err: (s2_den_r == '0)};

  bpc_div #(.PW($bits(diva_pay_t))) u_div_t (
    .clk, .rst_n, .en,
    .in_valid (v2_r), .in_num (da_num), .in_den (da_den), .in_pay (da_pay_in),
    .out_valid(da_vld), .out_quot(da_q), .out_pay(da_pay)
  );

  // Pressure divider hookup: the doubling goes before or after the divide.
  assign db_num = s11_b7_r[31] ? s11_b7_r : {s11_b7_r[30:0], 1'b0};
  assign db_den = (s11_b4_r == '0) ? 32'd1 : s11_b4_r;
  assign db_pay_in = '{t: s11_t_r, err: s11_err_r || (s11_b4_r == '0),
                       dbl: s11_b7_r[31]};

  bpc_div #(.PW($bits(divb_pay_t))) u_div_p (
    .clk, .rst_n, .en,
    .in_valid (v11_r), .in_num (db_num), .in_den (db_den), .in_pay (db_pay_in),
    .out_valid(db_vld), .out_quot(db_q), .out_pay(db_pay)
  );

  // Valid bits for the arithmetic stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r, v11_r} <= '0;
      {v13_r, v14_r, v15_r, v16_r, v17_r} <= '0;
    end else if (en) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= da_vld;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v13_r <= db_vld;
      v14_r <= v13_r;
      v15_r <= v14_r;
      v16_r <= v15_r;
      v17_r <= v16_r;
    end
  end

  // Temperature path up to the divider.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_m1_r  <= (signed'({16'd0, in_data.raw_temperature}) - ac6) * ac5;
      s1_up_r  <= {8'd0, in_data.raw_pressure >> (4'd8 - {2'd0, oss_r})};
      s2_x1_r  <= sdiv_pow2(s1_m1_r, 15);
      s2_den_r <= sdiv_pow2(s1_m1_r, 15) + md;
      s2_up_r  <= s1_up_r;
    end
  end

  // B5, temperature and B6.
  always_ff @(posedge clk) begin
    if (en) begin
      s3_b5_r  <= da_pay.x1 + (da_pay.neg ? 32'(-signed'(da_q)) : signed'(da_q));
      s3_up_r  <= da_pay.up;
      s3_err_r <= da_pay.err;
      s4_t_r   <= sdiv_pow2(s3_b5_r + 32'sd8, 4);
      s4_b6_r  <= s3_b5_r - C_B6_OFS;
      s4_up_r  <= s3_up_r;
      s4_err_r <= s3_err_r;
    end
  end

  // Products of B6 and their scaling.
  always_ff @(posedge clk) begin
    if (en) begin
      s5_sqm_r <= s4_b6_r * s4_b6_r;
      s5_m2_r  <= ac2 * s4_b6_r;
      s5_m3_r  <= ac3 * s4_b6_r;
      s5_t_r   <= s4_t_r;
      s5_up_r  <= s4_up_r;
      s5_err_r <= s4_err_r;
      s6_sq_r  <= sdiv_pow2(s5_sqm_r, 12);
      s6_x2a_r <= sdiv_pow2(s5_m2_r, 11);
      s6_x1c_r <= sdiv_pow2(s5_m3_r, 13);
      s6_t_r   <= s5_t_r;
      s6_up_r  <= s5_up_r;
      s6_err_r <= s5_err_r;
      s7_mb2_r <= b2 * s6_sq_r;
      s7_mb1_r <= b1 * s6_sq_r;
      s7_x2a_r <= s6_x2a_r;
      s7_x1c_r <= s6_x1c_r;
      s7_t_r   <= s6_t_r;
      s7_up_r  <= s6_up_r;
      s7_err_r <= s6_err_r;
    end
  end

  // B3, B4 and B7.
  always_ff @(posedge clk) begin
    if (en) begin
      s8_b3p_r   <= ((ac1 <<< 2) + sdiv_pow2(s7_mb2_r, 11) + s7_x2a_r) <<< oss_r;
      s8_x3c_r   <= sdiv_pow2(s7_x1c_r + sdiv_pow2(s7_mb1_r, 16) + 32'sd2, 2);
      s8_t_r     <= s7_t_r;
      s8_up_r    <= s7_up_r;
      s8_err_r   <= s7_err_r;
      s9_b3_r    <= sdiv_pow2(s8_b3p_r + 32'sd2, 2);
      s9_b4m_r   <= ac4 * (unsigned'(s8_x3c_r) + C_B4_OFS);
      s9_t_r     <= s8_t_r;
      s9_up_r    <= s8_up_r;
      s9_err_r   <= s8_err_r;
      s10_b4_r   <= s9_b4m_r >> 15;
      s10_diff_r <= s9_up_r - unsigned'(s9_b3_r);
      s10_t_r    <= s9_t_r;
      s10_err_r  <= s9_err_r;
      s11_b7_r   <= s10_diff_r * (C_B7_MUL >> oss_r);
      s11_b4_r   <= s10_b4_r;
      s11_t_r    <= s10_t_r;
      s11_err_r  <= s10_err_r;
    end
  end

  // Final pressure correction.
  always_ff @(posedge clk) begin
    if (en) begin
      s13_p_r    <= db_pay.dbl ? signed'({db_q[30:0], 1'b0}) : signed'(db_q);
      s13_t_r    <= db_pay.t;
      s13_err_r  <= db_pay.err;
      s14_pd_r   <= sdiv_pow2(s13_p_r, 8);
      s14_ma_r   <= C_P_X2 * s13_p_r;
      s14_p_r    <= s13_p_r;
      s14_t_r    <= s13_t_r;
      s14_err_r  <= s13_err_r;
      s15_x1m_r  <= s14_pd_r * s14_pd_r;
      s15_x2_r   <= sdiv_pow2(s14_ma_r, 16);
      s15_p_r    <= s14_p_r;
      s15_t_r    <= s14_t_r;
      s15_err_r  <= s14_err_r;
      s16_x1m2_r <= s15_x1m_r * C_P_X1;
      s16_x2_r   <= s15_x2_r;
      s16_p_r    <= s15_p_r;
      s16_t_r    <= s15_t_r;
      s16_err_r  <= s15_err_r;
    end
  end

  // Output register; a divide error forces both values to zero.
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.divide_error <= s16_err_r;
      out_r.temperature  <= s16_err_r ? '0 : s16_t_r;
      out_r.pressure     <= s16_err_r ? '0 :
        s16_p_r + sdiv_pow2(sdiv_pow2(s16_x1m2_r, 16) + s16_x2_r + C_P_OFS, 4);
    end
  end

  assign out_valid = v17_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/core/bpc_checker.sv -----
// Port-level checker for the pressure compensation top level, with its bind.
// Depends on bpc_pkg for the word types and on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bpc_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire bpc_pkg::in_word_t          in_data,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire bpc_pkg::out_word_t         out_data,
  input wire logic                       cfg_psel,
  input wire logic                       cfg_penable,
  input wire logic                       cfg_pwrite,
  input wire logic [bpc_pkg::ADDR_W-1:0] cfg_paddr,
  input wire logic [bpc_pkg::CFG_DW-1:0] cfg_pwdata,
  input wire logic [bpc_pkg::CFG_DW-1:0] cfg_prdata,
  input wire logic                       cfg_pready
);
  import bpc_pkg::*;

  // A held result word stays valid.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // A divide error always comes with zeroed values.
  `ASSERT_SAME(a_err_zero, clk, rst_n, out_valid && out_data.divide_error,
    out_data.temperature == '0 && out_data.pressure == '0)
  // With no word waiting at the output the block takes input.
  `ASSERT_SAME(a_ready_empty, clk, rst_n, !out_valid, in_ready)
  // The input side stalls only because the output side does.
  `ASSERT_SAME(a_ready_drain, clk, rst_n, out_valid && out_ready, in_ready)

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (.*);

`default_nettype wire
